[sv/nmse_pkg.sv]
// Shared types and constants for the non-max suppression engine.
// Holds the controller/datapath command and status structs and the decay table.
// No dependencies.
package nmse_pkg;

	// decay table geometry: DECAY_N entries over x in [0, 16)
	localparam int DECAY_N     = 256;
	localparam int DECAY_IW    = 8;
	localparam int DECAY_SHIFT = 42 - DECAY_IW;
	localparam logic [63:0] DECAY_STEP = (64'd16 << 30) / DECAY_N;

	// quotient bits of the IoU division (Q1.15 result, up to 1.0)
	localparam int DIV_STEPS = 16;

	// configuration register indexes
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_MAX_SELECT    = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_SCORE_FLOOR   = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_OVERLAP_LIMIT = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_DECAY_SCALE   = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_CENTER_MODE   = 3'd4;

	// datapath operations
	localparam logic [4:0] OP_NONE       = 5'd0;
	localparam logic [4:0] OP_LOAD       = 5'd1;
	localparam logic [4:0] OP_SCAN_START = 5'd2;
	localparam logic [4:0] OP_SCAN_STEP  = 5'd3;
	localparam logic [4:0] OP_TAKE       = 5'd4;
	localparam logic [4:0] OP_BEST       = 5'd5;
	localparam logic [4:0] OP_PL_RD      = 5'd6;
	localparam logic [4:0] OP_BOX_RD     = 5'd7;
	localparam logic [4:0] OP_CORNER     = 5'd8;
	localparam logic [4:0] OP_DIFF       = 5'd9;
	localparam logic [4:0] OP_AREA       = 5'd10;
	localparam logic [4:0] OP_UNI        = 5'd11;
	localparam logic [4:0] OP_DIV        = 5'd12;
	localparam logic [4:0] OP_IOU        = 5'd13;
	localparam logic [4:0] OP_DROP       = 5'd14;
	localparam logic [4:0] OP_NEXT       = 5'd15;
	localparam logic [4:0] OP_SQ         = 5'd16;
	localparam logic [4:0] OP_TMUL       = 5'd17;
	localparam logic [4:0] OP_LUT        = 5'd18;
	localparam logic [4:0] OP_MULS       = 5'd19;
	localparam logic [4:0] OP_APPLY      = 5'd20;
	localparam logic [4:0] OP_DEC        = 5'd21;
	localparam logic [4:0] OP_PICK       = 5'd22;
	localparam logic [4:0] OP_FIN        = 5'd23;

	typedef struct packed {
		logic [4:0] op;
	} nmse_cmd_t;

	typedef struct packed {
		logic limit_hit;   // pick count reached the clamped max_select
		logic scan_end;    // scan pointer reached load count
		logic found;       // scan found a live candidate
		logic k_more;      // more picks to compare and score above floor
		logic div_done;
		logic hard;        // decay_scale is zero
		logic iou_ge;      // iou >= overlap_limit
		logic keep;
		logic same;        // score unchanged by the comparisons
		logic pend_valid;  // a pick waits for its end flag
		logic out_free;    // output register can take a beat
	} nmse_status_t;

	typedef logic [DECAY_N-1:0][15:0] decay_lut_t;

	// exp(-x) samples in Q1.15 via a repeated-product of a series step
	function automatic decay_lut_t build_decay_lut();
		decay_lut_t lut;
		logic [63:0] term;
		logic [63:0] p;
		logic [63:0] r;
		logic signed [63:0] sum;
		term = 64'd1 << 30;
		sum  = 64'sd1 << 30;
		p    = 64'd1 << 30;
		for (int n = 1; n <= 24; n++) begin
			term = ((term * DECAY_STEP) >> 30) / 64'(n);
			if (n % 2 == 1) sum = sum - $signed(term);
			else            sum = sum + $signed(term);
		end
		r = (sum > 0) ? 64'(sum) : 64'd0;
		for (int k = 0; k < DECAY_N; k++) begin
			lut[k] = 16'((p + 64'd16384) >> 15);
			p = (p * r + (64'd1 << 29)) >> 30;
		end
		return lut;
	endfunction

	localparam decay_lut_t DECAY_LUT = build_decay_lut();

endpackage

[sv/nmse_ctrl.sv]
// Controller state machine of the non-max suppression engine.
// Sequences load, candidate scan, IoU compare and emit; depends on nmse_pkg.
module nmse_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  final_box,
	input  nmse_pkg::nmse_status_t st,
	output logic                  in_ready,
	output nmse_pkg::nmse_cmd_t   cmd
);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_SEL   = 5'd1;
	localparam logic [4:0] S_SCAN  = 5'd2;
	localparam logic [4:0] S_DRAIN = 5'd3;
	localparam logic [4:0] S_PCHK  = 5'd4;
	localparam logic [4:0] S_BEST  = 5'd5;
	localparam logic [4:0] S_CTOP  = 5'd6;
	localparam logic [4:0] S_PLW   = 5'd7;
	localparam logic [4:0] S_BOXW  = 5'd8;
	localparam logic [4:0] S_DIFF  = 5'd9;
	localparam logic [4:0] S_AREA  = 5'd10;
	localparam logic [4:0] S_UNI   = 5'd11;
	localparam logic [4:0] S_DIV   = 5'd12;
	localparam logic [4:0] S_IOU   = 5'd13;
	localparam logic [4:0] S_HARD  = 5'd14;
	localparam logic [4:0] S_SQ    = 5'd15;
	localparam logic [4:0] S_TMUL  = 5'd16;
	localparam logic [4:0] S_LUT   = 5'd17;
	localparam logic [4:0] S_MULS  = 5'd18;
	localparam logic [4:0] S_APPLY = 5'd19;
	localparam logic [4:0] S_DEC   = 5'd20;
	localparam logic [4:0] S_PICK  = 5'd21;
	localparam logic [4:0] S_FIN   = 5'd22;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign in_ready = (state_q == S_LOAD);

	always_comb begin
		state_d = state_q;
		cmd.op  = nmse_pkg::OP_NONE;
		case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.op = nmse_pkg::OP_LOAD;
					if (final_box) state_d = S_SEL;
				end
			end
			S_SEL: begin
				if (st.limit_hit) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = nmse_pkg::OP_SCAN_START;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.scan_end) state_d = S_DRAIN;
				else cmd.op = nmse_pkg::OP_SCAN_STEP;
			end
			S_DRAIN: state_d = S_PCHK;
			S_PCHK: begin
				if (!st.found) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = nmse_pkg::OP_TAKE;
					state_d = S_BEST;
				end
			end
			S_BEST: begin
				cmd.op  = nmse_pkg::OP_BEST;
				state_d = S_CTOP;
			end
			S_CTOP: begin
				if (st.k_more) begin
					cmd.op  = nmse_pkg::OP_PL_RD;
					state_d = S_PLW;
				end else begin
					state_d = S_DEC;
				end
			end
			S_PLW: begin
				cmd.op  = nmse_pkg::OP_BOX_RD;
				state_d = S_BOXW;
			end
			S_BOXW: begin
				cmd.op  = nmse_pkg::OP_CORNER;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.op  = nmse_pkg::OP_DIFF;
				state_d = S_AREA;
			end
			S_AREA: begin
				cmd.op  = nmse_pkg::OP_AREA;
				state_d = S_UNI;
			end
			S_UNI: begin
				cmd.op  = nmse_pkg::OP_UNI;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (st.div_done) state_d = S_IOU;
				else cmd.op = nmse_pkg::OP_DIV;
			end
			S_IOU: begin
				cmd.op  = nmse_pkg::OP_IOU;
				state_d = st.hard ? S_HARD : S_SQ;
			end
			S_HARD: begin
				if (st.iou_ge) begin
					cmd.op  = nmse_pkg::OP_DROP;
					state_d = S_DEC;
				end else begin
					cmd.op  = nmse_pkg::OP_NEXT;
					state_d = S_CTOP;
				end
			end
			S_SQ: begin
				cmd.op  = nmse_pkg::OP_SQ;
				state_d = S_TMUL;
			end
			S_TMUL: begin
				cmd.op  = nmse_pkg::OP_TMUL;
				state_d = S_LUT;
			end
			S_LUT: begin
				cmd.op  = nmse_pkg::OP_LUT;
				state_d = S_MULS;
			end
			S_MULS: begin
				cmd.op  = nmse_pkg::OP_MULS;
				state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.op  = nmse_pkg::OP_APPLY;
				state_d = S_CTOP;
			end
			S_DEC: begin
				cmd.op  = nmse_pkg::OP_DEC;
				state_d = (st.keep && st.same) ? S_PICK : S_SEL;
			end
			S_PICK: begin
				if (!st.pend_valid || st.out_free) begin
					cmd.op  = nmse_pkg::OP_PICK;
					state_d = S_SEL;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.op  = nmse_pkg::OP_FIN;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else state_q <= state_d;
	end

endmodule

[sv/nmse_dp.sv]
// Datapath of the non-max suppression engine: config registers, box and score
// memories, scan compare, IoU unit with serial divider, decay and output register.
// Depends on nmse_pkg.
module nmse_dp #(
	parameter int MAX_BOXES = 256,
	parameter int MAX_PICKS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nmse_pkg::nmse_cmd_t               cmd,
	output nmse_pkg::nmse_status_t            st,
	input  logic                              cfg_we,
	input  logic [nmse_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [15:0]                       cfg_data,
	input  logic signed [15:0]                coord_a,
	input  logic signed [15:0]                coord_b,
	input  logic signed [15:0]                coord_c,
	input  logic signed [15:0]                coord_d,
	input  logic signed [15:0]                box_score,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [7:0]                        picked_index,
	output logic signed [15:0]                picked_score,
	output logic                              pick_valid,
	output logic                              end_of_picks
);

	localparam int IW  = $clog2(MAX_BOXES);
	localparam int LCW = $clog2(MAX_BOXES + 1);
	localparam int PCW = $clog2(MAX_PICKS + 1);
	localparam int PLW = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;

	typedef struct packed {
		logic signed [17:0] y0;
		logic signed [17:0] x0;
		logic signed [17:0] y1;
		logic signed [17:0] x1;
	} corner_t;

	// corners in half-LSB units, each axis ordered min then max
	function automatic corner_t box_corners(input logic [63:0] w, input logic ctr);
		corner_t r;
		logic signed [17:0] a2, b2, c2, d2, ce, de, ya, yb, xa, xb;
		a2 = {w[15], w[15:0], 1'b0};
		b2 = {w[31], w[31:16], 1'b0};
		c2 = {w[47], w[47:32], 1'b0};
		d2 = {w[63], w[63:48], 1'b0};
		ce = {{2{w[47]}}, w[47:32]};
		de = {{2{w[63]}}, w[63:48]};
		if (ctr) begin
			xa = a2 - ce; xb = a2 + ce;
			ya = b2 - de; yb = b2 + de;
		end else begin
			ya = a2; xa = b2; yb = c2; xb = d2;
		end
		r.y0 = (ya < yb) ? ya : yb;
		r.y1 = (ya < yb) ? yb : ya;
		r.x0 = (xa < xb) ? xa : xb;
		r.x1 = (xa < xb) ? xb : xa;
		return r;
	endfunction

	logic [4:0] op;
	assign op = cmd.op;

	// configuration
	logic [6:0]         max_select_q;
	logic signed [15:0] floor_q;
	logic [15:0]        olap_q;
	logic [15:0]        decay_q;
	logic               center_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_select_q <= '0;
			floor_q      <= '0;
			olap_q       <= 16'h8000;
			decay_q      <= '0;
			center_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				nmse_pkg::CFG_MAX_SELECT:    max_select_q <= cfg_data[6:0];
				nmse_pkg::CFG_SCORE_FLOOR:   floor_q      <= $signed(cfg_data);
				nmse_pkg::CFG_OVERLAP_LIMIT: olap_q       <= cfg_data;
				nmse_pkg::CFG_DECAY_SCALE:   decay_q      <= cfg_data;
				nmse_pkg::CFG_CENTER_MODE:   center_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// control registers
	logic [LCW-1:0]     load_cnt_q;
	logic [PCW-1:0]     pick_cnt_q;
	logic [MAX_BOXES-1:0] live_q;
	logic [LCW-1:0]     scan_q;
	logic               s1_valid_q;
	logic               found_q;
	logic [4:0]         div_cnt_q;
	logic               keep_q;
	logic               pend_valid_q;
	logic               out_valid_q;

	// payload registers
	logic [IW-1:0]      s1_idx_q;
	logic               s1_live_q;
	logic [IW-1:0]      best_q;
	logic signed [15:0] best_s_q;
	logic signed [15:0] s_q;
	logic signed [15:0] orig_q;
	logic [PCW-1:0]     rchk_q;
	logic [PCW-1:0]     k_q;
	logic [63:0]        box_a_q;
	corner_t            ca_q, cb_q;
	logic [16:0]        dya_q, dxa_q, dyb_q, dxb_q;
	logic signed [18:0] iy_q, ix_q;
	logic               ipos_q;
	logic [33:0]        area_a_q, area_b_q, inter_q;
	logic               deg_q;
	logic [34:0]        uni_q;
	logic [35:0]        rem_q;
	logic [15:0]        quo_q;
	logic [15:0]        iou_q;
	logic [31:0]        sq_q;
	logic [46:0]        t_q;
	logic [15:0]        w_q;
	logic signed [32:0] prod_q;
	logic [7:0]         pend_idx_q;
	logic signed [15:0] pend_s_q;
	logic [7:0]         out_idx_q;
	logic signed [15:0] out_s_q;
	logic               out_pv_q;
	logic               out_eop_q;

	// memory read data
	logic [63:0]        bx_rd_q;
	logic [15:0]        ls_rd_q;
	logic [PCW-1:0]     rc_rd_q;
	logic [IW-1:0]      pl_rd_q;

	logic [63:0] box_mem [MAX_BOXES];
	logic [15:0] ls_mem  [MAX_BOXES];
	logic [PCW-1:0] rc_mem [MAX_BOXES];
	logic [IW-1:0] pl_mem [MAX_PICKS];

	logic               load_ok;
	logic               load_we;
	logic               requeue;
	logic [7:0]         limit;
	logic [PCW-1:0]     k_dec;
	logic [IW-1:0]      load_addr;
	logic [IW-1:0]      ls_raddr;
	logic [IW-1:0]      ls_waddr;
	logic [15:0]        ls_wdata;
	logic               ls_we;
	logic [IW-1:0]      rc_waddr;
	logic [PCW-1:0]     rc_wdata;
	logic               rc_we;
	logic [IW-1:0]      bx_raddr;
	logic               push;
	logic [7:0]         push_idx;
	logic signed [15:0] push_s;
	logic               push_pv;
	logic               push_eop;

	assign load_ok   = (load_cnt_q < LCW'(MAX_BOXES));
	assign load_we   = (op == nmse_pkg::OP_LOAD) && load_ok;
	assign load_addr = load_cnt_q[IW-1:0];
	assign requeue   = keep_q && (s_q != orig_q) && (s_q > floor_q);
	assign k_dec     = k_q - PCW'(1);
	assign limit     = ({1'b0, max_select_q} > 8'(MAX_PICKS)) ? 8'(MAX_PICKS)
	                   : {1'b0, max_select_q};

	// memory ports
	assign ls_we    = load_we || ((op == nmse_pkg::OP_DEC) && requeue);
	assign ls_waddr = load_we ? load_addr : best_q;
	assign ls_wdata = load_we ? box_score : s_q;
	assign ls_raddr = (op == nmse_pkg::OP_SCAN_STEP) ? scan_q[IW-1:0] : best_q;
	assign rc_we    = load_we || (op == nmse_pkg::OP_DEC);
	assign rc_waddr = load_we ? load_addr : best_q;
	assign rc_wdata = load_we ? '0 : pick_cnt_q;
	assign bx_raddr = (op == nmse_pkg::OP_BOX_RD) ? pl_rd_q : best_q;

	always_ff @(posedge clk) begin
		if (load_we) box_mem[load_addr] <= {coord_d, coord_c, coord_b, coord_a};
		bx_rd_q <= box_mem[bx_raddr];
	end

	always_ff @(posedge clk) begin
		if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
		ls_rd_q <= ls_mem[ls_raddr];
	end

	always_ff @(posedge clk) begin
		if (rc_we) rc_mem[rc_waddr] <= rc_wdata;
		rc_rd_q <= rc_mem[best_q];
	end

	always_ff @(posedge clk) begin
		if (op == nmse_pkg::OP_PICK) pl_mem[pick_cnt_q[PLW-1:0]] <= best_q;
		pl_rd_q <= pl_mem[k_dec[PLW-1:0]];
	end

	// IoU and decay arithmetic
	corner_t            ca_d, cb_d;
	logic signed [17:0] ylo, yhi, xlo, xhi;
	logic signed [18:0] iy_d, ix_d;
	logic               ge;
	logic [35:0]        rem_sub;
	logic signed [32:0] adj;
	logic signed [15:0] s_new;

	always_comb begin
		ca_d = box_corners(box_a_q, center_q);
		cb_d = box_corners(bx_rd_q, center_q);
		ylo  = (ca_q.y0 > cb_q.y0) ? ca_q.y0 : cb_q.y0;
		yhi  = (ca_q.y1 < cb_q.y1) ? ca_q.y1 : cb_q.y1;
		xlo  = (ca_q.x0 > cb_q.x0) ? ca_q.x0 : cb_q.x0;
		xhi  = (ca_q.x1 < cb_q.x1) ? ca_q.x1 : cb_q.x1;
		iy_d = {yhi[17], yhi} - {ylo[17], ylo};
		ix_d = {xhi[17], xhi} - {xlo[17], xlo};
		ge      = (rem_q >= {1'b0, uni_q});
		rem_sub = ge ? (rem_q - {1'b0, uni_q}) : rem_q;
		adj     = prod_q[32] ? (prod_q + 33'sd32767) : prod_q;
		s_new   = 16'(adj >>> 15);
	end

	always_ff @(posedge clk) begin
		case (op)
			nmse_pkg::OP_BEST: begin
				s_q     <= ls_rd_q;
				orig_q  <= ls_rd_q;
				rchk_q  <= rc_rd_q;
				box_a_q <= bx_rd_q;
				k_q     <= pick_cnt_q;
			end
			nmse_pkg::OP_CORNER: begin
				ca_q <= ca_d;
				cb_q <= cb_d;
			end
			nmse_pkg::OP_DIFF: begin
				dya_q  <= 17'(ca_q.y1 - ca_q.y0);
				dxa_q  <= 17'(ca_q.x1 - ca_q.x0);
				dyb_q  <= 17'(cb_q.y1 - cb_q.y0);
				dxb_q  <= 17'(cb_q.x1 - cb_q.x0);
				iy_q   <= iy_d;
				ix_q   <= ix_d;
				ipos_q <= (iy_d > 19'sd0) && (ix_d > 19'sd0);
			end
			nmse_pkg::OP_AREA: begin
				area_a_q <= dya_q * dxa_q;
				area_b_q <= dyb_q * dxb_q;
				inter_q  <= ipos_q ? (iy_q[16:0] * ix_q[16:0]) : 34'd0;
				deg_q    <= (dya_q == 17'd0) || (dxa_q == 17'd0) || (dyb_q == 17'd0)
				            || (dxb_q == 17'd0) || !ipos_q;
			end
			nmse_pkg::OP_UNI: begin
				uni_q <= 35'(area_a_q) + 35'(area_b_q) - 35'(inter_q);
				rem_q <= 36'(inter_q);
				quo_q <= '0;
			end
			nmse_pkg::OP_DIV: begin
				rem_q <= {rem_sub[34:0], 1'b0};
				quo_q <= {quo_q[14:0], ge};
			end
			nmse_pkg::OP_IOU:   iou_q <= deg_q ? 16'd0 : quo_q;
			nmse_pkg::OP_NEXT:  k_q <= k_dec;
			nmse_pkg::OP_SQ:    sq_q <= iou_q * iou_q;
			nmse_pkg::OP_TMUL:  t_q <= sq_q[30:0] * decay_q;
			nmse_pkg::OP_LUT: begin
				if (t_q[46:42] == 5'd0)
					w_q <= nmse_pkg::DECAY_LUT[t_q[nmse_pkg::DECAY_SHIFT +: nmse_pkg::DECAY_IW]];
				else
					w_q <= 16'd0;
			end
			nmse_pkg::OP_MULS:  prod_q <= s_q * $signed({1'b0, w_q});
			nmse_pkg::OP_APPLY: begin
				s_q <= s_new;
				k_q <= k_dec;
			end
			default: ;
		endcase
	end

	// scan pipeline payload
	always_ff @(posedge clk) begin
		s1_idx_q  <= scan_q[IW-1:0];
		s1_live_q <= live_q[scan_q[IW-1:0]];
		if (s1_valid_q && s1_live_q && (!found_q || ($signed(ls_rd_q) > best_s_q))) begin
			best_q   <= s1_idx_q;
			best_s_q <= ls_rd_q;
		end
		if (op == nmse_pkg::OP_PICK) begin
			pend_idx_q <= 8'(best_q);
			pend_s_q   <= s_q;
		end
	end

	// output beat
	always_comb begin
		push     = ((op == nmse_pkg::OP_PICK) && pend_valid_q) || (op == nmse_pkg::OP_FIN);
		push_idx = pend_valid_q ? pend_idx_q : 8'd0;
		push_s   = pend_valid_q ? pend_s_q : 16'sd0;
		push_pv  = pend_valid_q;
		push_eop = (op == nmse_pkg::OP_FIN);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_idx_q <= push_idx;
			out_s_q   <= push_s;
			out_pv_q  <= push_pv;
			out_eop_q <= push_eop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q   <= '0;
			pick_cnt_q   <= '0;
			live_q       <= '0;
			scan_q       <= '0;
			s1_valid_q   <= 1'b0;
			found_q      <= 1'b0;
			div_cnt_q    <= '0;
			keep_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			s1_valid_q <= (op == nmse_pkg::OP_SCAN_STEP);
			if (s1_valid_q && s1_live_q && (!found_q || ($signed(ls_rd_q) > best_s_q)))
				found_q <= 1'b1;
			if (push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (op)
				nmse_pkg::OP_LOAD: begin
					if (load_ok) begin
						live_q[load_addr] <= (box_score > floor_q);
						load_cnt_q <= load_cnt_q + LCW'(1);
					end
				end
				nmse_pkg::OP_SCAN_START: begin
					scan_q  <= '0;
					found_q <= 1'b0;
				end
				nmse_pkg::OP_SCAN_STEP: scan_q <= scan_q + LCW'(1);
				nmse_pkg::OP_TAKE:      live_q[best_q] <= 1'b0;
				nmse_pkg::OP_BEST:      keep_q <= 1'b1;
				nmse_pkg::OP_UNI:       div_cnt_q <= '0;
				nmse_pkg::OP_DIV:       div_cnt_q <= div_cnt_q + 5'd1;
				nmse_pkg::OP_DROP:      keep_q <= 1'b0;
				nmse_pkg::OP_DEC: begin
					if (requeue) live_q[best_q] <= 1'b1;
				end
				nmse_pkg::OP_PICK: begin
					pick_cnt_q   <= pick_cnt_q + PCW'(1);
					pend_valid_q <= 1'b1;
				end
				nmse_pkg::OP_FIN: begin
					live_q       <= '0;
					load_cnt_q   <= '0;
					pick_cnt_q   <= '0;
					pend_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		st.limit_hit  = (8'(pick_cnt_q) >= limit);
		st.scan_end   = (scan_q == load_cnt_q);
		st.found      = found_q;
		st.k_more     = (k_q > rchk_q) && (s_q > floor_q);
		st.div_done   = (div_cnt_q == 5'(nmse_pkg::DIV_STEPS));
		st.hard       = (decay_q == 16'd0);
		st.iou_ge     = (iou_q >= olap_q);
		st.keep       = keep_q;
		st.same       = (s_q == orig_q);
		st.pend_valid = pend_valid_q;
		st.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign picked_index = out_idx_q;
	assign picked_score = out_s_q;
	assign pick_valid   = out_pv_q;
	assign end_of_picks = out_eop_q;

endmodule

[sv/non_max_suppression_engine_core.sv]
// Top level of the non-max suppression engine: controller plus datapath.
// Depends on nmse_pkg, nmse_ctrl and nmse_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | coord_a..coord_d, box_score, final_box
//  out     | out_valid / out_ready| picked_index, picked_score, pick_valid, end_of_picks
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// Load: one box beat per cycle. The beat with final_box starts selection and
// in_ready stays low until the group's last result beat enters the output register.
// A selection round starts the scan, reads the score of every loaded box, drains the
// scan pipeline and checks for a live best box, then takes, decides and picks it.
// Each earlier pick it is compared with adds a pass through the 16-step serial IoU
// divider, then a hard-mode check or, in soft mode, the decay and score update steps.
// Reset clears control state only; box and score memories need no clearing pass.
// A stalled output holds its beat; selection waits only when it must push a beat.
module non_max_suppression_engine_core #(
	parameter int MAX_BOXES = 256,
	parameter int MAX_PICKS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [nmse_pkg::CFG_IW-1:0] cfg_index,
	input  logic [15:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          coord_a,
	input  logic signed [15:0]          coord_b,
	input  logic signed [15:0]          coord_c,
	input  logic signed [15:0]          coord_d,
	input  logic signed [15:0]          box_score,
	input  logic                        final_box,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  picked_index,
	output logic signed [15:0]          picked_score,
	output logic                        pick_valid,
	output logic                        end_of_picks
);

	nmse_pkg::nmse_cmd_t    cmd;
	nmse_pkg::nmse_status_t st;

	nmse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.final_box (final_box),
		.st        (st),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	nmse_dp #(
		.MAX_BOXES (MAX_BOXES),
		.MAX_PICKS (MAX_PICKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.coord_a      (coord_a),
		.coord_b      (coord_b),
		.coord_c      (coord_c),
		.coord_d      (coord_d),
		.box_score    (box_score),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.picked_index (picked_index),
		.picked_score (picked_score),
		.pick_valid   (pick_valid),
		.end_of_picks (end_of_picks)
	);

endmodule

[sv/nmse_checker.sv]
// Port-level checks for the non-max suppression engine, bound to the top level.
// Depends on non_max_suppression_engine_core.
module nmse_port_checks (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        final_box,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [7:0]                  picked_index,
	input logic signed [15:0]          picked_score,
	input logic                        pick_valid,
	input logic                        end_of_picks
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(picked_index)
		&& $stable(picked_score) && $stable(pick_valid) && $stable(end_of_picks))
		else $error("result beat changed while stalled");

	// an empty group is reported by a single closing beat
	a_empty_eop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pick_valid |-> end_of_picks && picked_index == 8'd0
		&& picked_score == 16'sd0)
		else $error("empty-group beat malformed");

	// the closing box of a group stops loading
	a_final_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && final_box |=> !in_ready)
		else $error("input still open after final box");

	// loading resumes only after the group's closing beat is produced
	a_reopen_after_eop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid && end_of_picks)
		else $error("input reopened without closing beat");

endmodule

bind non_max_suppression_engine_core nmse_port_checks u_nmse_port_checks (.*);

[sim/nmse_checker.sv]
// Checker for the non-max suppression engine: watches config, box and pick channels.
// Predicts the expected picks of each group and compares every output beat.
// Depends on nmse_pkg for the config register indexes.
`timescale 1ns / 100ps

module nmse_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [nmse_pkg::CFG_IW-1:0] cfg_index,
	input  logic [15:0]                 cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic signed [15:0]          coord_a,
	input  logic signed [15:0]          coord_b,
	input  logic signed [15:0]          coord_c,
	input  logic signed [15:0]          coord_d,
	input  logic signed [15:0]          box_score,
	input  logic                        final_box,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [7:0]                  picked_index,
	input  logic signed [15:0]          picked_score,
	input  logic                        pick_valid,
	input  logic                        end_of_picks,
	output int                          fail_count,
	output int                          pending,
	output int                          beats_checked
);

	localparam int NBOX  = 256;
	localparam int NPICK = 64;
	localparam int NLUT  = 256;

	typedef struct {
		logic [7:0]         idx;
		logic signed [15:0] score;
		logic               pv;
		logic               eop;
	} pick_t;

	pick_t picks_due[$];

	// config copy
	int          sel_max;
	int          floor_q;
	int          iou_lim;
	int          decay_k;
	bit          ctr_mode;

	// group state
	logic signed [15:0] boxes [NBOX][4];
	int          score_now [NBOX];
	int          seen_upto [NBOX];
	bit          alive [NBOX];
	int          pick_ids [NPICK];
	int          n_loaded;
	logic [15:0] weight_lut [NLUT];

	initial begin
		longint unsigned stp, trm, pr, rr;
		longint          acc;
		stp = (64'd16 << 30) / NLUT;
		trm = 64'd1 << 30;
		acc = 64'sd1 << 30;
		for (int n = 1; n <= 24; n++) begin
			trm = ((trm * stp) >> 30) / n;
			if (n % 2) acc -= longint'(trm);
			else acc += longint'(trm);
		end
		rr = acc > 0 ? acc : 0;
		pr = 64'd1 << 30;
		for (int k = 0; k < NLUT; k++) begin
			weight_lut[k] = 16'((pr + 64'd16384) >> 15);
			pr = (pr * rr + (64'd1 << 29)) >> 30;
		end
	end

	// corners in half-LSB units, min/max normalized
	function automatic void box_edges(input int i, output longint y0, output longint x0,
			output longint y1, output longint x1);
		longint a, b, c, d, ya, xa, yb, xb;
		a = boxes[i][0]; b = boxes[i][1]; c = boxes[i][2]; d = boxes[i][3];
		if (ctr_mode) begin
			xa = 2*a - c; xb = 2*a + c; ya = 2*b - d; yb = 2*b + d;
		end else begin
			ya = 2*a; xa = 2*b; yb = 2*c; xb = 2*d;
		end
		y0 = ya < yb ? ya : yb; y1 = ya < yb ? yb : ya;
		x0 = xa < xb ? xa : xb; x1 = xa < xb ? xb : xa;
	endfunction

	function automatic longint overlap_q15(input int i, input int j);
		longint ay0, ax0, ay1, ax1, by0, bx0, by1, bx1, ar_a, ar_b, iy, ix, ov, un;
		box_edges(i, ay0, ax0, ay1, ax1);
		box_edges(j, by0, bx0, by1, bx1);
		ar_a = (ay1 - ay0) * (ax1 - ax0);
		ar_b = (by1 - by0) * (bx1 - bx0);
		if (ar_a <= 0 || ar_b <= 0) return 0;
		iy = (ay1 < by1 ? ay1 : by1) - (ay0 > by0 ? ay0 : by0);
		ix = (ax1 < bx1 ? ax1 : bx1) - (ax0 > bx0 ? ax0 : bx0);
		if (iy <= 0 || ix <= 0) return 0;
		ov = iy * ix;
		un = ar_a + ar_b - ov;
		if (un <= 0) return 0;
		return (ov * 32768) / un;
	endfunction

	function automatic longint decay_weight(input longint iou);
		longint unsigned t, ix;
		t  = longint'(decay_k) * iou * iou;
		ix = (t * NLUT) >> 42;
		if (ix >= NLUT) return 0;
		return weight_lut[ix];
	endfunction

	// runs selection for the loaded group and queues its picks
	task automatic select_group();
		int lim, npk, best, s, orig;
		bit found, keep;
		pick_t pk;
		lim = sel_max < NPICK ? sel_max : NPICK;
		npk = 0;
		while (npk < lim) begin
			found = 0; best = 0; keep = 1;
			for (int i = 0; i < n_loaded; i++)
				if (alive[i] && (!found || score_now[i] > score_now[best])) begin
					best = i; found = 1;
				end
			if (!found) break;
			alive[best] = 0;
			s = score_now[best];
			orig = s;
			for (int k = npk; k > seen_upto[best]; k--) begin
				longint iou;
				iou = overlap_q15(best, pick_ids[(k - 1) % NPICK]);
				if (decay_k != 0) begin
					s = int'((longint'(s) * decay_weight(iou)) / 32768);
				end else if (iou >= iou_lim) begin
					keep = 0;
					break;
				end
				if (s <= floor_q) break;
			end
			seen_upto[best] = npk;
			if (!keep) continue;
			if (s == orig) begin
				pick_ids[npk % NPICK] = best;
				pk.idx = 8'(best); pk.score = 16'(s); pk.pv = 1'b1; pk.eop = 1'b0;
				picks_due = {picks_due, pk};
				npk++;
			end else if (s > floor_q) begin
				score_now[best] = s;
				alive[best] = 1;
			end
		end
		if (npk == 0) begin
			pk.idx = 8'd0; pk.score = 16'sd0; pk.pv = 1'b0; pk.eop = 1'b1;
			picks_due = {picks_due, pk};
		end else begin
			picks_due[$].eop = 1;
		end
		for (int i = 0; i < NBOX; i++) alive[i] = 0;
		n_loaded = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pick_t exp_b;
		if (!arst_n) begin
			sel_max = 0; floor_q = 0; iou_lim = 32768; decay_k = 0; ctr_mode = 0;
			n_loaded = 0;
			for (int i = 0; i < NBOX; i++) alive[i] = 0;
			picks_due.delete();
			fail_count = 0;
			beats_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nmse_pkg::CFG_MAX_SELECT:    sel_max = cfg_data[6:0];
					nmse_pkg::CFG_SCORE_FLOOR:   floor_q = $signed(cfg_data);
					nmse_pkg::CFG_OVERLAP_LIMIT: iou_lim = cfg_data;
					nmse_pkg::CFG_DECAY_SCALE:   decay_k = cfg_data;
					nmse_pkg::CFG_CENTER_MODE:   ctr_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				beats_checked++;
				if (picks_due.size() == 0) begin
					$error("pick beat with nothing expected: index %0d", picked_index);
					fail_count++;
				end else begin
					exp_b = picks_due.pop_front();
					if (picked_index !== exp_b.idx) begin
						$error("picked_index: expected %0d, got %0d", exp_b.idx, picked_index);
						fail_count++;
					end
					if (picked_score !== exp_b.score) begin
						$error("picked_score: expected %0d, got %0d", exp_b.score, picked_score);
						fail_count++;
					end
					if (pick_valid !== exp_b.pv) begin
						$error("pick_valid: expected %0d, got %0d", exp_b.pv, pick_valid);
						fail_count++;
					end
					if (end_of_picks !== exp_b.eop) begin
						$error("end_of_picks: expected %0d, got %0d", exp_b.eop, end_of_picks);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				// boxes past the store size are dropped without an index
				if (n_loaded < NBOX) begin
					boxes[n_loaded][0] = coord_a;
					boxes[n_loaded][1] = coord_b;
					boxes[n_loaded][2] = coord_c;
					boxes[n_loaded][3] = coord_d;
					score_now[n_loaded] = box_score;
					seen_upto[n_loaded] = 0;
					alive[n_loaded] = (int'(box_score) > floor_q);
					n_loaded++;
				end
				if (final_box) select_group();
			end
		end
		pending = picks_due.size();
	end

endmodule

[sim/tb.sv]
// Testbench top for non_max_suppression_engine_core: stimulus, idling and verdict.
// Depends on nmse_pkg, the engine RTL and nmse_checker.
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 3000000;

	logic                         clk = 0;
	logic                         arst_n;
	logic                         cfg_we = 0;
	logic [nmse_pkg::CFG_IW-1:0]  cfg_index = '0;
	logic [15:0]                  cfg_data = '0;
	logic                         in_valid = 0;
	logic                         in_ready;
	logic signed [15:0]  coord_a = 0, coord_b = 0, coord_c = 0, coord_d = 0;
	logic signed [15:0]  box_score = 0;
	logic                final_box = 0;
	logic                out_valid;
	logic                out_ready = 0;
	logic [7:0]          picked_index;
	logic signed [15:0]  picked_score;
	logic                pick_valid;
	logic                end_of_picks;

	int fail_count, pending, beats_checked;
	int cycles = 0;
	int idle_pct = 0;    // sender gap chance per cycle
	int stall_pct = 0;   // receiver stall chance per cycle
	bit center_fmt = 0;  // mirrors the center_mode register
	int groups_sent = 0, boxes_sent = 0;
	logic signed [15:0] last_score = 0;
	logic signed [15:0] clu_y = 0, clu_x = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	non_max_suppression_engine_core u_dut (.*);

	nmse_checker u_chk (.*);

	// receiver: random stalls at the phase's rate
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// one register write; cfg_we is lowered by cfg_done
	task automatic cfg_write(input logic [nmse_pkg::CFG_IW-1:0] idx, input logic [15:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic cfg_done();
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// one box beat; returns at the edge that accepted it
	task automatic send_box(input logic signed [15:0] a, b, c, d, sc, input bit last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid  <= 1;
		coord_a   <= a;
		coord_b   <= b;
		coord_c   <= c;
		coord_d   <= d;
		box_score <= sc;
		final_box <= last;
		do @(posedge clk); while (!in_ready);
		boxes_sent++;
		if (last) groups_sent++;
		last_score = sc;
	endtask

	// block idle: every pick back, then a margin for the tail of selection
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_config(input int msel, input int flr, input int olim, input int dk,
			input bit cm);
		cfg_write(nmse_pkg::CFG_MAX_SELECT, 16'(msel));
		cfg_write(nmse_pkg::CFG_SCORE_FLOOR, 16'(flr));
		cfg_write(nmse_pkg::CFG_OVERLAP_LIMIT, 16'(olim));
		cfg_write(nmse_pkg::CFG_DECAY_SCALE, 16'(dk));
		cfg_write(nmse_pkg::CFG_CENTER_MODE, 16'(cm));
		cfg_done();
		center_fmt = cm;
	endtask

	// random box: mostly near a cluster so IoU is non-trivial
	task automatic rand_box(input bit last);
		logic signed [15:0] a, b, c, d, sc;
		int kind, sz_h, sz_w;
		kind = $urandom_range(99);
		sz_h = $urandom_range(64, 1024);
		sz_w = $urandom_range(64, 1024);
		if (kind < 70) begin
			a = 16'(clu_y + $signed(16'($urandom_range(0, 256))) - 128);
			b = 16'(clu_x + $signed(16'($urandom_range(0, 256))) - 128);
			if (center_fmt) begin
				c = ($urandom_range(9) == 0) ? 16'(-sz_w) : 16'(sz_w);
				d = 16'(sz_h);
			end else if ($urandom_range(7) == 0) begin
				// reversed corners, normalized by the block
				c = a; d = b; a = 16'(a + sz_h); b = 16'(b + sz_w);
			end else begin
				c = 16'(a + sz_h); d = 16'(b + sz_w);
			end
		end else if (kind < 85) begin
			a = 16'($urandom); b = 16'($urandom); c = 16'($urandom); d = 16'($urandom);
		end else begin
			// zero area on one axis
			a = clu_y; b = clu_x;
			c = center_fmt ? 16'sd0 : clu_y;
			d = 16'(sz_h);
		end
		if ($urandom_range(4) == 0) sc = last_score;
		else if ($urandom_range(2) == 0) sc = 16'($urandom);
		else sc = 16'($urandom_range(0, 32767));
		send_box(a, b, c, d, sc, last);
	endtask

	task automatic rand_group(input int n);
		clu_y = 16'(int'($urandom_range(0, 8000)) - 4000);
		clu_x = 16'(int'($urandom_range(0, 8000)) - 4000);
		for (int i = 0; i < n; i++) rand_box(i == n - 1);
	endtask

	int msel_tab [8] = '{5, 64, 127, 0, 10, 64, 3, 20};
	int flr_tab  [8] = '{-32768, 0, -1000, 0, 32767, -32768, 100, -200};
	int olim_tab [8] = '{16384, 32768, 0, 65535, 8000, 20000, 16384, 32768};
	int dk_tab   [8] = '{0, 0, 0, 0, 128, 65535, 512, 300};

	initial begin
		int sent;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: hard mode, corners
		set_config(8, -32768, 16384, 0, 0);
		// identical boxes with tied scores, both suppressed by a higher-scored overlapping box
		send_box(100, 100, 300, 300, 1000, 0);
		send_box(100, 100, 300, 300, 1000, 0);
		send_box(110, 100, 300, 310, 2000, 1);
		// extremes of every field, score at both ends, degenerate box
		send_box(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
		send_box(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 0);
		send_box(16'shffff, 16'sh5555, 16'shffff, 16'shaaaa, 16'sh0001, 0);
		send_box(0, 0, 0, 0, 16'shffff, 1);
		// single-box group
		send_box(-50, -50, 50, 50, 500, 1);
		drain();
		// soft mode, center form, disjoint and overlapping boxes
		set_config(64, -32768, 32768, 65535, 1);
		send_box(0, 0, 200, 200, 30000, 0);
		send_box(10, 10, 200, 200, 29000, 0);
		send_box(5000, 5000, 100, 100, 28000, 0);
		send_box(0, 0, -200, 200, 27000, 1);
		drain();
		// empty selection: nothing above the floor, then max_select zero
		set_config(5, 32767, 32768, 0, 0);
		send_box(0, 0, 100, 100, 16'sh7fff, 1);
		drain();
		set_config(0, -32768, 32768, 0, 0);
		send_box(0, 0, 100, 100, 1234, 1);
		drain();

		// random phases: every setting extreme, four idling styles
		for (int p = 0; p < 8; p++) begin
			set_config(msel_tab[p], flr_tab[p], olim_tab[p], dk_tab[p], p % 2);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 77; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 77; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			sent = 0;
			while (sent < 22) begin
				int n;
				n = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
				rand_group(n);
				sent += n;
			end
			drain();
		end
		idle_pct = 0;
		stall_pct = 0;

		$display("tb: %0d groups, %0d boxes, %0d pick beats checked", groups_sent,
			boxes_sent, beats_checked);
		$display("tb: hard and soft modes, both box forms, empty groups, stalls and gaps");
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
